>>> rtl/core/tsrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsrs_pkg;
    localparam int MaxBlocks = 8;
    localparam int IdxW = $clog2(MaxBlocks);
    localparam int CntW = $clog2(MaxBlocks + 1);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] range_start;
        logic [31:0] range_end;
    } in_word_t;

    typedef struct packed {
        logic        covered;
        logic        dropped;
        logic [31:0] ack_now;
        logic [3:0]  blocks_held;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ABSORB,
        ST_SHDN,
        ST_LAST,
        ST_FIND,
        ST_SHUP,
        ST_INSERT,
        ST_MERGE,
        ST_QUERY,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;          // latch input word
        logic rd_set;        // read block rd_idx into rd regs
        logic [IdxW-1:0] rd_idx;
        logic init;          // ack := s
        logic set_ack_end;   // ack := e
        logic absorb;        // ack := max(ack, rd end)
        logic set_s_ack;     // s := max(s, ack)
        logic q_step;        // s := rd end when s <= rd end
        logic w_load;        // widened block := rd widened by (s,e)
        logic merge_grow;    // widened end := max with rd end
        logic wr_copy;       // mem[wr_idx] := rd
        logic wr_new;        // mem[wr_idx] := (s,e)
        logic wr_widen;      // mem[wr_idx] := widened block
        logic [IdxW-1:0] wr_idx;
        logic cnt_inc;
        logic cnt_set;
        logic [CntW-1:0] cnt_val;
        logic set_cov;
        logic set_drop;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t opcode;
        logic [CntW-1:0] count;
        logic empty_rng;     // e <= s
        logic e_le_ack;
        logic s_le_ack;
        logic blk_s_le_ack;  // rd start <= ack
        logic s_le_blk_end;
        logic e_lt_blk_s;
        logic last_lt_s;     // rd end < s
        logic q_s_lt_bs;
        logic q_e_le_be;
        logic m_bs_le_we;    // rd start <= widened end
    } sts_t;

    function automatic logic s_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic s_le(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || s_lt(a, b);
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/tcp_sack_range_scoreboard_top.sv
// Flow: init, no-op and trivial items go straight from decode to the result; other
// add and query items walk the stored blocks one at a time before the result.
// Handshake: one word at a time; in_ready returns the cycle after the result is
// loaded, later while an earlier result still waits to be taken.
// Reset: asynchronous active low; ack and block count clear to zero, table
// contents are left undefined and never read before being written.
`timescale 1ns / 1ps
`default_nettype none
module tcp_sack_range_scoreboard_top
    import tsrs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data
);
    cmd_t cmd;
    sts_t sts;
    logic busy, out_set, out_valid_reg;

    assign in_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_set)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end
    assign out_valid = out_valid_reg;

    tsrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && !busy),
        .out_free (!out_valid_reg || out_ready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .out_set  (out_set)
    );

    tsrs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (out_data)
    );
endmodule
`default_nettype wire

>>> rtl/core/tsrs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tsrs_datapath
    import tsrs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_word,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    output out_word_t      out_word
);
    logic [31:0] mem_s [MaxBlocks];
    logic [31:0] mem_e [MaxBlocks];
    logic [31:0] rd_s_reg, rd_e_reg;
    logic [1:0]  op_reg;
    logic [31:0] s_reg, e_reg, w_s_reg, w_e_reg;
    logic [31:0] ack_reg, ack_next;
    logic [CntW-1:0] cnt_reg;
    logic cov_reg, drop_reg;
    out_word_t out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_set)
        begin
            rd_s_reg <= mem_s[cmd.rd_idx];
            rd_e_reg <= mem_e[cmd.rd_idx];
        end
        if (cmd.wr_copy)
        begin
            mem_s[cmd.wr_idx] <= rd_s_reg;
            mem_e[cmd.wr_idx] <= rd_e_reg;
        end
        else if (cmd.wr_new)
        begin
            mem_s[cmd.wr_idx] <= s_reg;
            mem_e[cmd.wr_idx] <= e_reg;
        end
        else if (cmd.wr_widen)
        begin
            mem_s[cmd.wr_idx] <= w_s_reg;
            mem_e[cmd.wr_idx] <= w_e_reg;
        end
    end

    always_comb
    begin
        ack_next = ack_reg;
        if (cmd.init)
            ack_next = s_reg;
        else if (cmd.set_ack_end)
            ack_next = e_reg;
        else if (cmd.absorb && s_lt(ack_reg, rd_e_reg))
            ack_next = rd_e_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            ack_reg <= ack_next;
            if (cmd.cnt_set)
                cnt_reg <= cmd.cnt_val;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_word.opcode;
            s_reg    <= in_word.range_start;
            e_reg    <= in_word.range_end;
            cov_reg  <= 1'b0;
            drop_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_cov)
                cov_reg <= 1'b1;
            if (cmd.set_drop)
                drop_reg <= 1'b1;
            if (cmd.set_s_ack && s_lt(s_reg, ack_reg))
                s_reg <= ack_reg;
            else if (cmd.q_step && s_le(s_reg, rd_e_reg))
                s_reg <= rd_e_reg;
        end
        if (cmd.w_load)
        begin
            w_s_reg <= s_lt(s_reg, rd_s_reg) ? s_reg : rd_s_reg;
            w_e_reg <= s_lt(rd_e_reg, e_reg) ? e_reg : rd_e_reg;
        end
        else if (cmd.merge_grow && s_lt(w_e_reg, rd_e_reg))
            w_e_reg <= rd_e_reg;
        if (cmd.out_load)
            out_reg <= '{covered: cov_reg, dropped: drop_reg, ack_now: ack_reg,
                         blocks_held: 4'(cnt_reg)};
    end

    always_comb
    begin
        sts.opcode       = op_t'(op_reg);
        sts.count        = cnt_reg;
        sts.empty_rng    = s_le(e_reg, s_reg);
        sts.e_le_ack     = s_le(e_reg, ack_reg);
        sts.s_le_ack     = s_le(s_reg, ack_reg);
        sts.blk_s_le_ack = s_le(rd_s_reg, ack_reg);
        sts.s_le_blk_end = s_le(s_reg, rd_e_reg);
        sts.e_lt_blk_s   = s_lt(e_reg, rd_s_reg);
        sts.last_lt_s    = s_lt(rd_e_reg, s_reg);
        sts.q_s_lt_bs    = s_lt(s_reg, rd_s_reg);
        sts.q_e_le_be    = s_le(e_reg, rd_e_reg);
        sts.m_bs_le_we   = s_le(rd_s_reg, w_e_reg);
    end

    assign out_word = out_reg;
endmodule
`default_nettype wire

>>> rtl/core/tsrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tsrs_ctrl
    import tsrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_free,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy,
    output logic      out_set
);
    state_t state_reg, state_next;
    logic [CntW-1:0] i_reg, i_next;   // walk index
    logic [CntW-1:0] j_reg, j_next;   // secondary index
    logic [CntW-1:0] i_inc, j_inc;

    assign i_inc = i_reg + CntW'(1);
    assign j_inc = j_reg + CntW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        busy       = 1'b1;
        out_set    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_DONE;
                i_next     = '0;
                unique case (sts.opcode)
                    OP_ADD:
                    begin
                        if (!sts.empty_rng && !sts.e_le_ack)
                        begin
                            if (sts.s_le_ack)
                            begin
                                cmd.set_ack_end = 1'b1;
                                if (sts.count != '0)
                                begin
                                    cmd.rd_set = 1'b1;
                                    cmd.rd_idx = '0;
                                    state_next = ST_ABSORB;
                                end
                            end
                            else if (sts.count == '0)
                            begin
                                cmd.wr_new  = 1'b1;
                                cmd.wr_idx  = '0;
                                cmd.cnt_inc = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_set = 1'b1;
                                cmd.rd_idx = IdxW'(sts.count - CntW'(1));
                                state_next = ST_LAST;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!sts.empty_rng)
                        begin
                            if (sts.e_le_ack)
                                cmd.set_cov = 1'b1;
                            else if (sts.count != '0)
                            begin
                                cmd.set_s_ack = 1'b1;
                                cmd.rd_set    = 1'b1;
                                cmd.rd_idx    = '0;
                                state_next    = ST_QUERY;
                            end
                        end
                    end
                    OP_INIT:
                    begin
                        cmd.init    = 1'b1;
                        cmd.cnt_set = 1'b1;
                        cmd.cnt_val = '0;
                    end
                    OP_NOP: ;
                endcase
            end
            ST_ABSORB:
            begin
                // rd holds block i
                if (sts.blk_s_le_ack)
                begin
                    cmd.absorb = 1'b1;
                    if (i_inc < sts.count)
                    begin
                        i_next     = i_inc;
                        cmd.rd_set = 1'b1;
                        cmd.rd_idx = IdxW'(i_inc);
                    end
                    else
                    begin
                        cmd.cnt_set = 1'b1;
                        cmd.cnt_val = '0;
                        state_next  = ST_DONE;
                    end
                end
                else if (i_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    j_next     = '0;
                    state_next = ST_SHDN;
                end
            end
            ST_SHDN:
            begin
                // move block i (in rd) down to slot j
                cmd.wr_copy = 1'b1;
                cmd.wr_idx  = IdxW'(j_reg);
                if (i_inc < sts.count)
                begin
                    i_next     = i_inc;
                    j_next     = j_inc;
                    cmd.rd_set = 1'b1;
                    cmd.rd_idx = IdxW'(i_inc);
                end
                else
                begin
                    cmd.cnt_set = 1'b1;
                    cmd.cnt_val = j_inc;
                    state_next  = ST_DONE;
                end
            end
            ST_LAST:
            begin
                // rd holds the last block
                if (sts.last_lt_s)
                begin
                    if (sts.count >= CntW'(MaxBlocks))
                        cmd.set_drop = 1'b1;
                    else
                    begin
                        cmd.wr_new  = 1'b1;
                        cmd.wr_idx  = IdxW'(sts.count);
                        cmd.cnt_inc = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next     = '0;
                    cmd.rd_set = 1'b1;
                    cmd.rd_idx = '0;
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                // rd holds block i; look for the first block with s <= end
                if (sts.s_le_blk_end)
                begin
                    if (sts.e_lt_blk_s)
                    begin
                        if (sts.count >= CntW'(MaxBlocks))
                        begin
                            cmd.set_drop = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            j_next     = sts.count - CntW'(1);
                            cmd.rd_set = 1'b1;
                            cmd.rd_idx = IdxW'(sts.count - CntW'(1));
                            state_next = ST_SHUP;
                        end
                    end
                    else
                    begin
                        cmd.w_load = 1'b1;
                        j_next     = i_inc;
                        if (i_inc < sts.count)
                        begin
                            cmd.rd_set = 1'b1;
                            cmd.rd_idx = IdxW'(i_inc);
                        end
                        state_next = ST_MERGE;
                    end
                end
                else if (i_inc < sts.count)
                begin
                    i_next     = i_inc;
                    cmd.rd_set = 1'b1;
                    cmd.rd_idx = IdxW'(i_inc);
                end
                else
                    state_next = ST_DONE;
            end
            ST_SHUP:
            begin
                // rd holds block j; move it up one slot
                cmd.wr_copy = 1'b1;
                cmd.wr_idx  = IdxW'(j_inc);
                if (j_reg == i_reg)
                    state_next = ST_INSERT;
                else
                begin
                    j_next     = j_reg - CntW'(1);
                    cmd.rd_set = 1'b1;
                    cmd.rd_idx = IdxW'(j_reg - CntW'(1));
                end
            end
            ST_INSERT:
            begin
                cmd.wr_new  = 1'b1;
                cmd.wr_idx  = IdxW'(i_reg);
                cmd.cnt_inc = 1'b1;
                state_next  = ST_DONE;
            end
            ST_MERGE:
            begin
                // rd holds block j; w holds widened block i
                if (j_reg < sts.count && sts.m_bs_le_we)
                begin
                    cmd.merge_grow = 1'b1;
                    j_next         = j_inc;
                    if (j_inc < sts.count)
                    begin
                        cmd.rd_set = 1'b1;
                        cmd.rd_idx = IdxW'(j_inc);
                    end
                end
                else
                begin
                    cmd.wr_widen = 1'b1;
                    cmd.wr_idx   = IdxW'(i_reg);
                    if (j_reg == i_inc)
                        state_next = ST_DONE;
                    else if (j_reg >= sts.count)
                    begin
                        cmd.cnt_set = 1'b1;
                        cmd.cnt_val = i_inc;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // close the gap: blocks j.. move to i+1..
                        i_next     = j_reg;
                        j_next     = i_inc;
                        state_next = ST_SHDN;
                    end
                end
            end
            ST_QUERY:
            begin
                // rd holds block i
                if (sts.q_s_lt_bs)
                    state_next = ST_DONE;
                else if (sts.q_e_le_be)
                begin
                    cmd.set_cov = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.q_step = 1'b1;
                    if (i_inc < sts.count)
                    begin
                        i_next     = i_inc;
                        cmd.rd_set = 1'b1;
                        cmd.rd_idx = IdxW'(i_inc);
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    out_set      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        sts.count <= CntW'(MaxBlocks))
        else $error("block count above table size");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("word loaded while busy");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_set |=> state_reg == ST_IDLE)
        else $error("result issued outside done");
`endif
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import tsrs_pkg::*;

    class sack_scoreboard;
        logic [31:0] ack;
        logic [31:0] bs[MaxBlocks];
        logic [31:0] be[MaxBlocks];
        int          nblk;
        out_word_t   pending[$];
        int          mismatches;
        int          checked;
        int          drops;
        int          hits;

        function new();
            ack = '0;
            nblk = 0;
            mismatches = 0;
            checked = 0;
            drops = 0;
            hits = 0;
        endfunction

        function bit lt(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d[31];
        endfunction

        function bit le(logic [31:0] a, logic [31:0] b);
            return (a == b) || lt(a, b);
        endfunction

        function void drop_blk(int i);
            for (int k = i; k + 1 < nblk; k++)
            begin
                bs[k] = bs[k + 1];
                be[k] = be[k + 1];
            end
            nblk--;
        endfunction

        function bit put_blk(int i, logic [31:0] s, logic [31:0] e);
            if (nblk >= MaxBlocks)
                return 0;
            for (int k = nblk; k > i; k--)
            begin
                bs[k] = bs[k - 1];
                be[k] = be[k - 1];
            end
            bs[i] = s;
            be[i] = e;
            nblk++;
            return 1;
        endfunction

        function bit fold_range(logic [31:0] s, logic [31:0] e);
            if (le(e, s) || le(e, ack))
                return 0;
            if (le(s, ack))
            begin
                ack = e;
                while (nblk > 0 && le(bs[0], ack))
                begin
                    if (lt(ack, be[0]))
                        ack = be[0];
                    drop_blk(0);
                end
                return 0;
            end
            if (nblk == 0 || lt(be[nblk - 1], s))
                return !put_blk(nblk, s, e);
            for (int b = 0; b < nblk; b++)
            begin
                if (le(s, be[b]))
                begin
                    if (lt(e, bs[b]))
                        return !put_blk(b, s, e);
                    if (lt(s, bs[b]))
                        bs[b] = s;
                    if (lt(be[b], e))
                        be[b] = e;
                    while (b + 1 < nblk && le(bs[b + 1], be[b]))
                    begin
                        if (lt(be[b], be[b + 1]))
                            be[b] = be[b + 1];
                        drop_blk(b + 1);
                    end
                    return 0;
                end
            end
            return 0;
        endfunction

        function bit range_acked(logic [31:0] s, logic [31:0] e);
            if (le(e, s))
                return 0;
            if (le(e, ack))
                return 1;
            if (lt(s, ack))
                s = ack;
            for (int b = 0; b < nblk; b++)
            begin
                if (lt(s, bs[b]))
                    return 0;
                if (le(e, be[b]))
                    return 1;
                if (le(s, be[b]))
                    s = be[b];
            end
            return 0;
        endfunction

        function void note_input(in_word_t w);
            out_word_t r;
            r = '0;
            case (op_t'(w.opcode))
                OP_ADD:   r.dropped = fold_range(w.range_start, w.range_end);
                OP_QUERY: r.covered = range_acked(w.range_start, w.range_end);
                OP_INIT:
                begin
                    ack = w.range_start;
                    nblk = 0;
                end
                default: ;
            endcase
            r.ack_now = ack;
            r.blocks_held = 4'(nblk);
            drops += r.dropped;
            hits += r.covered;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", got);
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got.covered !== exp.covered || got.dropped !== exp.dropped
                || got.ack_now !== exp.ack_now || got.blocks_held !== exp.blocks_held)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %0d %h %0d, got %0d %0d %h %0d",
                             exp.covered, exp.dropped, exp.ack_now, exp.blocks_held,
                             got.covered, got.dropped, got.ack_now, got.blocks_held);
            end
        endfunction
    endclass

    localparam int StallLimit = 20000;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 0;
    out_word_t out_data;

    sack_scoreboard sb = new();
    int  send_idle = 29;
    int  recv_idle = 82;
    bit  hold_recv = 0;
    int  idle_cycles = 0;
    int  words_sent = 0;

    tcp_sack_range_scoreboard_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= StallLimit)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAIL tcp_sack_range_scoreboard_top");
            $finish;
        end
    end

    task automatic send_word(op_t op, logic [31:0] s, logic [31:0] e);
        in_word_t w;
        w.opcode = op;
        w.range_start = s;
        w.range_end = e;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_word(logic [31:0] base);
        int        k;
        logic [31:0] s;
        logic [31:0] len;
        k = $urandom_range(99);
        if (k < 2)
        begin
            send_word(op_t'($urandom_range(3)), $urandom, $urandom);
            return;
        end
        s = base + $urandom_range(400) - 40;
        len = (k < 6) ? $urandom : $urandom_range(30);
        if (k < 6)
            send_word(OP_NOP, s, len);
        else if (k < 8)
            send_word(OP_INIT, $urandom_range(1) ? $urandom : base, $urandom);
        else if (k < 60)
            send_word(OP_ADD, s, s + len);
        else
            send_word(OP_QUERY, s, s + len);
    endtask

    initial
    begin
        logic [31:0] base;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every op, wrap, full table, widen-merge
        send_word(OP_QUERY, 32'd0, 32'd0);
        send_word(OP_ADD, 32'd10, 32'd5);
        send_word(OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_word(OP_ADD, 32'd0, 32'd20);
        send_word(OP_INIT, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_word(OP_ADD, 32'hFFFF_FFF8, 32'h8);
        send_word(OP_QUERY, 32'hFFFF_FFF0, 32'h4);
        send_word(OP_INIT, 32'd100, 32'd0);
        for (int i = 0; i < 9; i++)
            send_word(OP_ADD, 32'd200 + 32'(i) * 20, 32'd210 + 32'(i) * 20);
        send_word(OP_ADD, 32'd150, 32'd160);
        send_word(OP_ADD, 32'd205, 32'd245);
        send_word(OP_QUERY, 32'd200, 32'd250);
        send_word(OP_QUERY, 32'd205, 32'd275);
        send_word(OP_ADD, 32'd100, 32'd230);
        send_word(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_QUERY, 32'd0, 32'd300);
        send_word(OP_INIT, 32'h8000_0000, 32'h0);

        drain();
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle = 82;
                recv_idle = 29;
            end
            else if (phase == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            base = $urandom;
            send_word(OP_INIT, base, 32'd0);
            for (int n = 0; n < 600; n++)
            begin
                if (n == 300 && phase == 2)
                begin
                    hold_recv = 1;
                    fork
                        begin
                            repeat (400) @(posedge clk);
                            hold_recv = 0;
                        end
                    join_none
                end
                if (n % 120 == 119)
                    base = sb.ack;
                random_word(base);
            end
            drain();
        end

        $display("sent %0d words, checked %0d results", words_sent, sb.checked);
        $display("covered queries %0d, dropped adds %0d", sb.hits, sb.drops);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS tcp_sack_range_scoreboard_top");
        else
            $display("FAIL tcp_sack_range_scoreboard_top");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/tsrs_pkg.sv
rtl/core/tsrs_datapath.sv
rtl/core/tsrs_ctrl.sv
rtl/core/tcp_sack_range_scoreboard_top.sv
tb/testbench.sv
